[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Holds request and status codes, the controller state type and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned OCC_BITS   = 5;
  localparam int unsigned REQ_BITS   = 2;
  localparam int unsigned STAT_BITS  = 2;

  typedef enum logic [REQ_BITS-1:0] {
    OP_APPEND_REAR  = 2'd0,
    OP_REMOVE_FRONT = 2'd1,
    OP_REMOVE_REAR  = 2'd2,
    OP_INSERT_FRONT = 2'd3
  } dq_op_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } dq_status_t;

  typedef enum logic [0:0] {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } dq_state_t;

  // take: a request transaction is accepted this cycle.
  // load: the response register captures the finished result this cycle.
  typedef struct packed {
    logic take;
    logic load;
  } dq_cmd_t;

endpackage

[rtl/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl: controller for the double-ended queue
// Sequences one request at a time through the storage read and the response
// register, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  dq_state_t state;
  dq_state_t state_next;
  logic      rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.take       = 1'b0;
    cmd.load       = 1'b0;
    req_stall      = 1'b1;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      FSM_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = FSM_READ;
        end
      end
      FSM_READ: begin
        // Wait here until the response register is free.
        if (!rsp_valid || !rsp_stall) begin
          cmd.load       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

endmodule

[rtl/dq_datapath.sv]
// ----------------------------------------------------------------------------
// dq_datapath: storage ring, pointers and response register
// Holds the circular store, the front index and the entry count, and forms
// the response fields of each request.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dq_pkg::dq_cmd_t                 cmd,
  input  logic [dq_pkg::REQ_BITS-1:0]     req_type,
  input  logic [dq_pkg::VALUE_BITS-1:0]   item_value,
  output logic [dq_pkg::VALUE_BITS-1:0]   removed_value,
  output logic [dq_pkg::STAT_BITS-1:0]    status,
  output logic [dq_pkg::OCC_BITS-1:0]     occupancy
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W    = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data;

  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Result of the request in flight, held until the response register loads.
  dq_status_t     pend_status;
  logic           pend_taken;
  logic [CW-1:0]  pend_count;

  dq_status_t     status_next;
  logic           taken_next;
  logic           wr_en;
  logic [AW-1:0]  addr;
  logic [AW:0]    rear_sum;
  logic [AW:0]    last_sum;
  logic [AW-1:0]  rear_slot;
  logic [AW-1:0]  last_slot;
  logic           is_full;
  logic           is_empty;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
    return r[AW-1:0];
  endfunction

  always_comb begin
    is_full     = (count == FULL_COUNT);
    is_empty    = (count == '0);
    rear_sum    = {1'b0, front} + (AW + 1)'(count);
    last_sum    = rear_sum - (AW + 1)'(1);
    rear_slot   = wrap(rear_sum);
    last_slot   = wrap(last_sum);
    front_next  = front;
    count_next  = count;
    status_next = ST_OK;
    taken_next  = 1'b0;
    wr_en       = 1'b0;
    addr        = front;
    case (dq_op_t'(req_type))
      OP_APPEND_REAR: begin
        addr = rear_slot;
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_REMOVE_FRONT: begin
        addr = front;
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          taken_next = 1'b1;
          front_next = (front == LAST_SLOT) ? '0 : front + AW'(1);
          count_next = count - CW'(1);
        end
      end
      OP_REMOVE_REAR: begin
        addr = last_slot;
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          taken_next = 1'b1;
          count_next = count - CW'(1);
        end
      end
      OP_INSERT_FRONT: begin
        addr = (front == '0) ? LAST_SLOT : front - AW'(1);
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          front_next = addr;
          count_next = count + CW'(1);
        end
      end
      default: begin
        addr = front;
      end
    endcase
  end

  // Circular store: read-before-write at the one address of the request.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (wr_en) begin
        mem[addr] <= WORD_BITS'(item_value);
      end
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.take) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_status <= status_next;
      pend_taken  <= taken_next;
      pend_count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      removed_value <= pend_taken ? VALUE_BITS'(rd_data) : '0;
      status        <= pend_status;
      occupancy     <= OCC_BITS'(pend_count);
    end
  end

endmodule

[rtl/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue
// A ring of DEPTH words with a front index and an entry count, served by a
// request channel and a response channel.
// ----------------------------------------------------------------------------
// Each request transaction carries req_type (append at rear, remove from
// front, remove from rear, insert at front) and item_value. Every request
// yields exactly one response transaction: removed_value (the word taken out,
// zero for inserts and refused requests), status (ok, full or empty) and
// occupancy (entries stored after the request).
// A request is accepted when req_valid is high and req_stall is low. Its
// response appears with rsp_valid high after the ring access and the load
// of the response register, unless an older response still waits, and
// stays until a cycle in which rsp_stall is low. The block serves one
// request at a time: the single-port ring access happens at the accept
// edge, then the registered read data is loaded into the response register.
// No new request is taken until that load is done.
// A new request can be accepted while a finished response still waits; if
// the receiver keeps stalling, the next result waits in the datapath and
// req_stall stays high until the response register frees up.
// Synchronous reset empties the queue (front index and count cleared) and
// drops any response in flight; the ring contents are left as they are and
// only entries written since are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [dq_pkg::REQ_BITS-1:0]   req_type,
  input  logic [dq_pkg::VALUE_BITS-1:0] item_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [dq_pkg::VALUE_BITS-1:0] removed_value,
  output logic [dq_pkg::STAT_BITS-1:0]  status,
  output logic [dq_pkg::OCC_BITS-1:0]   occupancy
);
  import dq_pkg::*;

  // Commands from the controller to the datapath.
  dq_cmd_t cmd;

  // The controller owns both handshakes and sequences access and response.
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // The datapath holds the ring, the pointers and the response register.
  dq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .item_value    (item_value),
    .removed_value (removed_value),
    .status        (status),
    .occupancy     (occupancy)
  );

endmodule
